>>> rtl/retro_pixel_upscale_filter_assert.svh
// assertion macros used by the upscale filter block expander
`ifndef RETRO_PIXEL_UPSCALE_FILTER_ASSERT_SVH
`define RETRO_PIXEL_UPSCALE_FILTER_ASSERT_SVH

// same-cycle implication, checked on every clock outside reset
`define RPUF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every clock outside reset
`define RPUF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/rpuf_pkg.sv
// types and constants of the retro pixel upscale filter
package rpuf_pkg;

  // filter selection
  typedef enum logic {
    MODE_SCANLINE = 1'b0,
    MODE_DOT      = 1'b1
  } mode_t;

  // configuration register indexes
  localparam logic [2:0] REG_FILTER_MODE   = 3'd0;
  localparam logic [2:0] REG_DIM_BORDER    = 3'd1;
  localparam logic [2:0] REG_START_X       = 3'd2;
  localparam logic [2:0] REG_START_Y       = 3'd3;
  localparam logic [2:0] REG_WIDTH         = 3'd4;
  localparam logic [2:0] REG_HEIGHT        = 3'd5;
  localparam logic [2:0] REG_LEFT_EXTEND   = 3'd6;

  // source frame height, last line blends with nothing
  localparam int SOURCE_LINES = 240;

  // 0.6 as 154/256
  localparam logic [7:0] DIM_NUM = 8'd154;

  // last result index within a block
  localparam logic [3:0] SCAN_LAST_K = 4'd5;
  localparam logic [3:0] DOT_LAST_K  = 4'd15;

  // one source pixel ready for block expansion
  typedef struct packed {
    mode_t             mode;
    logic              border;
    logic [9:0]        base_col;
    logic [9:0]        base_row;
    logic [2:0][7:0]   copy_px;
    logic [2:0][7:0]   dim_px;
  } item_t;

endpackage

>>> rtl/rpuf_expand.sv
// block expander: turns one prepared pixel into its 6 or 16 output transactions
`include "retro_pixel_upscale_filter_assert.svh"

module rpuf_expand (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           item_valid,
  output logic           item_ready,
  input  rpuf_pkg::item_t item,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [47:0]    out_tdata,   // out_col[9:0], out_row[9:0], red, green, blue, 4'b0
  output logic           out_tlast    // block_last
);
  import rpuf_pkg::*;

  logic        exp_valid_r;
  item_t       exp_item_r;
  logic [3:0]  k_r;
  logic [3:0]  k_nxt;
  logic        out_valid_r;
  logic [47:0] out_data_r;
  logic        out_last_r;

  logic        out_load;
  logic        emit;
  logic        is_last;
  logic [3:0]  last_k;
  logic [1:0]  dx;
  logic [1:0]  dy;
  logic        black;
  logic [9:0]  px_col;
  logic [9:0]  px_row;
  logic [2:0][7:0] px_val;

  // handshake between block counter and output register
  assign out_load   = !out_valid_r || out_tready;
  assign emit       = exp_valid_r && out_load;
  assign last_k     = (exp_item_r.mode == MODE_DOT) ? DOT_LAST_K : SCAN_LAST_K;
  assign is_last    = (k_r == last_k);
  assign item_ready = !exp_valid_r || (emit && is_last);
  assign k_nxt      = is_last ? 4'd0 : k_r + 4'd1;

  // position and color of the current result
  always_comb begin
    if (exp_item_r.mode == MODE_DOT) begin
      dx = k_r[1:0];
      dy = k_r[3:2];
    end else begin
      dx = {1'b0, k_r[0]};
      dy = k_r[2:1];
    end
    black  = exp_item_r.border || (dx == 2'd3) || (dy == 2'd3);
    px_col = exp_item_r.base_col + {8'd0, dx};
    px_row = exp_item_r.base_row + {8'd0, dy};
    if (exp_item_r.mode == MODE_DOT) begin
      px_val = black ? '0 : exp_item_r.copy_px;
    end else begin
      px_val = (dy == 2'd2) ? exp_item_r.dim_px : exp_item_r.copy_px;
    end
  end

  // block counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_valid_r <= 1'b0;
      k_r         <= 4'd0;
    end else begin
      if (item_ready) begin
        exp_valid_r <= item_valid;
        k_r         <= 4'd0;
      end else if (emit) begin
        k_r <= k_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      exp_item_r <= item;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= exp_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= {4'd0, px_val[2], px_val[1], px_val[0], px_row, px_col};
      out_last_r <= is_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `RPUF_ASSERT_NOW(a_k_in_block, exp_valid_r, k_r <= last_k, "block counter past end")
  `RPUF_ASSERT_NOW(a_no_early_take, exp_valid_r && !(emit && is_last), !item_ready,
    "new pixel taken while block unfinished")
  `RPUF_ASSERT_NEXT(a_last_flag, emit && is_last, out_tvalid && out_tlast,
    "final block result not flagged")
  `RPUF_ASSERT_NEXT(a_mid_flag, emit && !is_last, out_tvalid && !out_tlast,
    "block flagged last too early")

endmodule

>>> rtl/retro_pixel_upscale_filter.sv
// retro pixel upscale filter top level: config registers, prep pipeline, expander
//
// Each accepted source pixel yields one output block, one transaction per clock when the
// output side is ready: a 2x3 block in scanline mode and a 4x4 block in dot-matrix mode.
// The block expander, which issues one result per cycle when the output side is ready,
// sets that rate. From input acceptance to the first result, a pixel passes the
// registered stages border test and blend sum, dim multiply, block counter and output
// register. Input acceptance overlaps the expansion of earlier pixels, so two further
// pixels can sit in the prep stages while a block is being sent. Configuration should be
// written only while the block is idle; it takes effect from the next accepted pixel.

module retro_pixel_upscale_filter (
  input  logic        clk,
  input  logic        rst_n,
  // source pixel stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // src_col, src_row, pix_red, pix_green, pix_blue,
                                  // below_red, below_green, below_blue
  // upscaled pixel stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // out_col[9:0], out_row[9:0], red, green, blue, 4'b0
  output logic        out_tlast,  // block_last
  // configuration writes
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [8:0]  cfg_wdata
);
  import rpuf_pkg::*;

  // configuration registers
  mode_t      mode_r;
  logic       dim_en_r;
  logic [7:0] start_x_r;
  logic [7:0] start_y_r;
  logic [8:0] width_r;
  logic [7:0] height_r;
  logic [7:0] left_ext_r;

  // stage 1
  logic            s1_valid_r;
  logic [7:0]      s1_col_r;
  logic [7:0]      s1_row_r;
  logic [2:0][7:0] s1_pix_r;
  logic [2:0][8:0] s1_sum_r;
  logic            s1_border_r;
  logic            s1_last_r;
  mode_t           s1_mode_r;
  logic            s1_dim_en_r;
  logic            s1_load;

  logic [7:0]      in_col;
  logic [7:0]      in_row;
  logic [2:0][7:0] in_pix;
  logic [2:0][7:0] in_below;
  logic [8:0]      y_end;
  logic [8:0]      x_first;
  logic [9:0]      x_end;
  logic            border_nxt;
  logic            last_nxt;

  // stage 2
  logic  s2_valid_r;
  item_t s2_item_r;
  item_t s2_item_nxt;
  logic  s2_load;
  logic  exp_ready;

  // configuration decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_SCANLINE;
      dim_en_r   <= 1'b0;
      start_x_r  <= 8'd0;
      start_y_r  <= 8'd0;
      width_r    <= 9'd256;
      height_r   <= 8'd240;
      left_ext_r <= 8'd0;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_FILTER_MODE: mode_r     <= mode_t'(cfg_wdata[0]);
        REG_DIM_BORDER:  dim_en_r   <= cfg_wdata[0];
        REG_START_X:     start_x_r  <= cfg_wdata[7:0];
        REG_START_Y:     start_y_r  <= cfg_wdata[7:0];
        REG_WIDTH:       width_r    <= cfg_wdata;
        REG_HEIGHT:      height_r   <= cfg_wdata[7:0];
        REG_LEFT_EXTEND: left_ext_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // unpack the input transaction
  assign in_col      = in_tdata[7:0];
  assign in_row      = in_tdata[15:8];
  assign in_pix[0]   = in_tdata[23:16];
  assign in_pix[1]   = in_tdata[31:24];
  assign in_pix[2]   = in_tdata[39:32];
  assign in_below[0] = in_tdata[47:40];
  assign in_below[1] = in_tdata[55:48];
  assign in_below[2] = in_tdata[63:56];

  // border window, sums kept wide so nothing wraps
  assign y_end   = {1'b0, start_y_r} + {1'b0, height_r};
  assign x_first = {1'b0, start_x_r} + {1'b0, left_ext_r};
  assign x_end   = {2'b0, start_x_r} + {1'b0, width_r};

  assign border_nxt = (in_row < start_y_r) ||
                      ({1'b0, in_row} >= y_end) ||
                      ({1'b0, in_col} < x_first) ||
                      ({2'b0, in_col} >= x_end);
  assign last_nxt   = ({3'b0, in_row} == 11'(SOURCE_LINES - 1));

  // pipeline advance
  assign s2_load   = !s2_valid_r || exp_ready;
  assign s1_load   = !s1_valid_r || s2_load;
  assign in_tready = s1_load;

  // stage 1: border test and blend sum
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_tvalid) begin
      s1_col_r    <= in_col;
      s1_row_r    <= in_row;
      s1_pix_r    <= in_pix;
      for (int i = 0; i < 3; i++) begin
        s1_sum_r[i] <= {1'b0, in_pix[i]} + {1'b0, in_below[i]};
      end
      s1_border_r <= border_nxt;
      s1_last_r   <= last_nxt;
      s1_mode_r   <= mode_r;
      s1_dim_en_r <= dim_en_r;
    end
  end

  // stage 2: dim multiply, border halving, block origin
  always_comb begin
    logic            halve;
    logic [8:0]      op;
    logic [16:0]     prod;
    logic [7:0]      dim;
    halve = (s1_mode_r == MODE_SCANLINE) && s1_border_r && s1_dim_en_r;
    s2_item_nxt.mode   = s1_mode_r;
    s2_item_nxt.border = s1_border_r;
    if (s1_mode_r == MODE_DOT) begin
      s2_item_nxt.base_col = {s1_col_r, 2'b00};
      s2_item_nxt.base_row = {s1_row_r, 2'b00};
    end else begin
      s2_item_nxt.base_col = {1'b0, s1_col_r, 1'b0};
      s2_item_nxt.base_row = {2'b00, s1_row_r} + {1'b0, s1_row_r, 1'b0};
    end
    for (int i = 0; i < 3; i++) begin
      // last line: c*154>>8 equals (2c)*154>>9
      op   = s1_last_r ? {s1_pix_r[i], 1'b0} : s1_sum_r[i];
      prod = {8'd0, op} * {9'd0, DIM_NUM};
      dim  = prod[16:9];
      s2_item_nxt.dim_px[i]  = halve ? {1'b0, dim[7:1]} : dim;
      s2_item_nxt.copy_px[i] = halve ? {1'b0, s1_pix_r[i][7:1]} : s1_pix_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_load) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid_r) begin
      s2_item_r <= s2_item_nxt;
    end
  end

  // stages 3 and 4: block expansion and output register
  rpuf_expand u_expand (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (s2_valid_r),
    .item_ready (exp_ready),
    .item       (s2_item_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
